// ===== rtl/bth_pkg.sv =====
package bth_pkg;

  localparam int unsigned HeapBytesDef = 65536;
  localparam int unsigned ChunkReset   = 4096;
  localparam int unsigned MinBlock     = 16;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_ZERO  = 2'd1;
  localparam logic [1:0] STAT_NOMEM = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT0, ST_INIT1, ST_INIT2, ST_INIT3,
    ST_GROW0, ST_GROW1, ST_GROW2,
    ST_MRG0, ST_MRG1, ST_MRG2, ST_MRG3, ST_MRG4, ST_MRG5, ST_MRG6,
    ST_FIT0, ST_FIT1,
    ST_PLC0, ST_PLC1, ST_PLC2, ST_PLC3, ST_PLC4, ST_PLC5,
    ST_FR0, ST_FR1, ST_FR2,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/boundary_tag_heap_allocator.sv =====
// Channel  Handshake                      Payload
// in       in_valid_i / in_ready_o        cmd_i, request_size_i, block_address_i
// out      out_valid_o / out_ready_i      address_o, status_o
// cfg      cfg_valid_i / cfg_ready_o      extend_chunk_bytes_i
//
// All heap tags live in one single-port word memory, so tag accesses are made one at a time.
// An allocate scans for the first free block that fits, growing the heap when none does,
// then places it, split when the rest can stand as a block. A free rewrites the block's
// tags, merging free neighbours. Reset and reinitialize rebuild the heap and add a chunk.
// A finished result waits in the output register while the next item is accepted; the
// next result then holds the block in its done state until that register is taken.
module boundary_tag_heap_allocator #(
  parameter int unsigned HEAP_BYTES = bth_pkg::HeapBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] request_size_i,
  input  logic [15:0] block_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] address_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] extend_chunk_bytes_i
);
  import bth_pkg::*;

  localparam int unsigned LogHeap = $clog2(HEAP_BYTES);
  localparam int unsigned AW = (LogHeap + 2 > 18) ? LogHeap + 2 : 18;
  localparam int unsigned Words = HEAP_BYTES / 4;
  localparam int unsigned WIW = $clog2(Words);
  localparam logic [AW-1:0] HeapLim = AW'(HEAP_BYTES);

  typedef logic [AW-1:0] addr_t;

  function automatic addr_t tsize(input logic [31:0] w);
    tsize = AW'({w[31:3], 3'b000});
  endfunction

  state_e state_q, state_d;
  logic [1:0] ctx_q, ctx_d;
  logic rep_q, rep_d;
  addr_t brk_q, brk_d, bp_q, bp_d, sz_q, sz_d, prv_q, prv_d, psz_q, psz_d;
  addr_t nsz_q, nsz_d, total_q, total_d, need_q, need_d, ext_q, ext_d, res_addr_q, res_addr_d;
  logic pu_q, pu_d, nu_q, nu_d, split_q, split_d;
  logic [1:0] res_status_q, res_status_d;
  logic [16:0] chunk_q;
  logic out_valid_q;
  logic [15:0] out_addr_q;
  logic [1:0] out_status_q;

  logic [31:0] mem [Words];
  logic [31:0] mem_rdata_q;
  logic rd_oob_q;
  logic mem_rd, mem_wr;
  addr_t mem_addr;
  logic [31:0] mem_wdata;
  logic in_rng;
  logic [31:0] rd_word;
  addr_t rd_size, chunk, grow_ext, plc_size;
  logic fit_ok, out_load;

  assign in_rng  = mem_addr < HeapLim;
  assign rd_word = rd_oob_q ? '0 : mem_rdata_q;
  assign rd_size = tsize(rd_word);

  always_comb begin
    chunk = (AW'(chunk_q) + AW'(7)) & ~AW'(7);
    if (chunk == '0) begin
      chunk = AW'(8);
    end
    grow_ext = (need_q > chunk) ? need_q : chunk;
    fit_ok   = (bp_q >= AW'(4)) && ((bp_q - AW'(4)) < HeapLim);
    plc_size = split_q ? need_q : sz_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr && in_rng) begin
      mem[mem_addr[WIW+1:2]] <= mem_wdata;
    end
    if (mem_rd) begin
      mem_rdata_q <= mem[mem_addr[WIW+1:2]];
      rd_oob_q    <= !in_rng;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_load    = (state_q == ST_DONE) && rep_q && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (cmd_i)
            CMD_ALLOC: state_d = (request_size_i == '0) ? ST_DONE : ST_FIT0;
            CMD_FREE:  state_d = ST_FR0;
            CMD_INIT:  state_d = ST_INIT0;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_INIT0: state_d = ST_INIT1;
      ST_INIT1: state_d = ST_INIT2;
      ST_INIT2: state_d = ST_INIT3;
      ST_INIT3: state_d = ST_GROW0;
      ST_GROW0: state_d = (brk_q + ext_q > HeapLim) ? ST_DONE : ST_GROW1;
      ST_GROW1: state_d = ST_GROW2;
      ST_GROW2: state_d = ST_MRG0;
      ST_MRG0:  state_d = ST_MRG1;
      ST_MRG1:  state_d = ST_MRG2;
      ST_MRG2:  state_d = ST_MRG3;
      ST_MRG3:  state_d = ST_MRG4;
      ST_MRG4:  state_d = ST_MRG5;
      ST_MRG5:  state_d = ST_MRG6;
      ST_MRG6:  state_d = (ctx_q == CMD_ALLOC) ? ST_PLC0 : ST_DONE;
      ST_FIT0:  state_d = fit_ok ? ST_FIT1 : ST_GROW0;
      ST_FIT1: begin
        if (rd_size == '0) begin
          state_d = ST_GROW0;
        end else if (!rd_word[0] && rd_size >= need_q) begin
          state_d = ST_PLC0;
        end else begin
          state_d = ST_FIT0;
        end
      end
      ST_PLC0:  state_d = ST_PLC1;
      ST_PLC1:  state_d = ST_PLC2;
      ST_PLC2:  state_d = ST_PLC3;
      ST_PLC3:  state_d = split_q ? ST_PLC4 : ST_DONE;
      ST_PLC4:  state_d = ST_PLC5;
      ST_PLC5:  state_d = ST_DONE;
      ST_FR0:   state_d = ST_FR1;
      ST_FR1:   state_d = ST_FR2;
      ST_FR2:   state_d = ST_MRG0;
      ST_DONE:  state_d = (!rep_q || out_load) ? ST_IDLE : ST_DONE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_rd    = 1'b0;
    mem_wr    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    case (state_q)
      ST_INIT0: begin
        mem_wr = 1'b1;
      end
      ST_INIT1: begin
        mem_wr = 1'b1; mem_addr = AW'(4); mem_wdata = 32'd9;
      end
      ST_INIT2: begin
        mem_wr = 1'b1; mem_addr = AW'(8); mem_wdata = 32'd9;
      end
      ST_INIT3: begin
        mem_wr = 1'b1; mem_addr = AW'(12); mem_wdata = 32'd1;
      end
      ST_GROW0: begin
        mem_wr = !(brk_q + ext_q > HeapLim);
        mem_addr = brk_q - AW'(4); mem_wdata = 32'(ext_q);
      end
      ST_GROW1: begin
        mem_wr = 1'b1; mem_addr = bp_q + ext_q - AW'(8); mem_wdata = 32'(ext_q);
      end
      ST_GROW2: begin
        mem_wr = 1'b1; mem_addr = bp_q + ext_q - AW'(4); mem_wdata = 32'd1;
      end
      ST_MRG0, ST_FIT0, ST_PLC0, ST_FR0: begin
        mem_rd = (state_q != ST_FIT0) || fit_ok; mem_addr = bp_q - AW'(4);
      end
      ST_MRG1: begin
        mem_rd = 1'b1; mem_addr = bp_q - AW'(8);
      end
      ST_MRG2: begin
        mem_rd = 1'b1; mem_addr = bp_q - rd_size - AW'(4);
      end
      ST_MRG3: begin
        mem_rd = 1'b1; mem_addr = bp_q + sz_q - AW'(4);
      end
      ST_MRG5: begin
        mem_wr = 1'b1; mem_wdata = 32'(total_d);
        if (!pu_q && !nu_q) begin
          mem_addr = bp_q + sz_q + nsz_q - AW'(8);
        end else if (!pu_q) begin
          mem_addr = bp_q + sz_q - AW'(8);
        end else begin
          mem_addr = bp_q - AW'(4);
        end
      end
      ST_MRG6: begin
        mem_wr = 1'b1; mem_wdata = 32'(total_q);
        mem_addr = !pu_q ? prv_q - AW'(4) : bp_q + total_q - AW'(8);
      end
      ST_PLC2: begin
        mem_wr = 1'b1; mem_addr = bp_q - AW'(4); mem_wdata = 32'(plc_size) | 32'd1;
      end
      ST_PLC3: begin
        mem_wr = 1'b1; mem_addr = bp_q + plc_size - AW'(8);
        mem_wdata = 32'(plc_size) | 32'd1;
      end
      ST_PLC4: begin
        mem_wr = 1'b1; mem_addr = bp_q + need_q - AW'(4); mem_wdata = 32'(sz_q - need_q);
      end
      ST_PLC5: begin
        mem_wr = 1'b1; mem_addr = bp_q + sz_q - AW'(8); mem_wdata = 32'(sz_q - need_q);
      end
      ST_FR1: begin
        mem_wr = 1'b1; mem_addr = bp_q - AW'(4); mem_wdata = 32'(rd_size);
      end
      ST_FR2: begin
        mem_wr = 1'b1; mem_addr = bp_q + sz_q - AW'(8); mem_wdata = 32'(sz_q);
      end
      default: begin
        mem_rd = 1'b0;
      end
    endcase
  end

  always_comb begin
    ctx_d        = ctx_q;
    rep_d        = rep_q;
    brk_d        = brk_q;
    bp_d         = bp_q;
    sz_d         = sz_q;
    prv_d        = prv_q;
    psz_d        = psz_q;
    pu_d         = pu_q;
    nsz_d        = nsz_q;
    nu_d         = nu_q;
    total_d      = total_q;
    need_d       = need_q;
    ext_d        = ext_q;
    split_d      = split_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    case (state_q)
      ST_IDLE: begin
        ctx_d        = cmd_i;
        rep_d        = 1'b1;
        res_addr_d   = '0;
        res_status_d = STAT_OK;
        bp_d         = (cmd_i == CMD_FREE) ? AW'(block_address_i) : AW'(MinBlock);
        need_d       = (request_size_i < 16'd8) ? AW'(MinBlock) :
                       (AW'(request_size_i) + AW'(15)) & ~AW'(7);
        if (cmd_i == CMD_ALLOC && request_size_i == '0) begin
          res_status_d = STAT_ZERO;
        end
      end
      ST_INIT3: begin
        brk_d = AW'(16);
        ext_d = chunk;
      end
      ST_GROW0: begin
        if (brk_q + ext_q > HeapLim) begin
          res_status_d = STAT_NOMEM;
        end else begin
          brk_d = brk_q + ext_q;
          bp_d  = brk_q;
        end
      end
      ST_MRG1: sz_d = rd_size;
      ST_MRG2: prv_d = bp_q - rd_size;
      ST_MRG3: begin
        psz_d = rd_size;
        pu_d  = rd_word[0];
      end
      ST_MRG4: begin
        nsz_d = rd_size;
        nu_d  = rd_word[0];
      end
      ST_MRG5: begin
        if (!pu_q && !nu_q) begin
          total_d = sz_q + nsz_q + psz_q;
        end else if (!pu_q) begin
          total_d = sz_q + psz_q;
        end else begin
          total_d = sz_q + (nu_q ? '0 : nsz_q);
        end
        total_d = total_d & ~AW'(7);
      end
      ST_MRG6: bp_d = !pu_q ? prv_q : bp_q;
      ST_FIT0: begin
        if (!fit_ok) begin
          ext_d = grow_ext;
        end
      end
      ST_FIT1: begin
        if (rd_size == '0) begin
          ext_d = grow_ext;
        end else if (rd_word[0] || rd_size < need_q) begin
          bp_d = bp_q + rd_size;
        end
      end
      ST_PLC1: begin
        sz_d    = rd_size;
        split_d = rd_size >= need_q + AW'(MinBlock);
      end
      ST_PLC2: res_addr_d = bp_q;
      ST_FR1:  sz_d = rd_size;
      default: begin
        rep_d = rep_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT0;
      ctx_q       <= CMD_INIT;
      rep_q       <= 1'b0;
      brk_q       <= '0;
      chunk_q     <= 17'(ChunkReset);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ctx_q   <= ctx_d;
      rep_q   <= rep_d;
      brk_q   <= brk_d;
      if (cfg_valid_i) begin
        chunk_q <= extend_chunk_bytes_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bp_q         <= bp_d;
    sz_q         <= sz_d;
    prv_q        <= prv_d;
    psz_q        <= psz_d;
    pu_q         <= pu_d;
    nsz_q        <= nsz_d;
    nu_q         <= nu_d;
    total_q      <= total_d;
    need_q       <= need_d;
    ext_q        <= ext_d;
    split_q      <= split_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_addr_q   <= res_addr_q[15:0];
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign address_o   = out_addr_q;
  assign status_o    = out_status_q;

  a_break_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    brk_q <= HeapLim) else $error("Heap break passed the heap size.");

  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_rd && mem_wr)) else $error("Memory read and write issued together.");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("Result appeared outside the done state.");

  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_OK |-> address_o == '0)
    else $error("Failed item carries an address.");

  a_merge_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MRG6 |-> total_q[2:0] == 3'b000)
    else $error("Merged block size is not a multiple of eight.");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import bth_pkg::*;

  localparam logic [1:0] CmdNone = 2'd3;
  localparam int unsigned WordCount = HeapBytesDef / 4;

  typedef longint unsigned u64_t;
  typedef struct packed {
    logic [15:0] address;
    logic [1:0]  status;
  } alloc_result_t;

  class heap_scoreboard;
    logic [31:0]   tags[WordCount];
    u64_t          brk;
    logic [16:0]   chunk_reg;
    alloc_result_t pending[$];
    int            errors;

    function void clear_heap();
      foreach (tags[i]) tags[i] = '0;
      brk = 0;
      chunk_reg = 17'(ChunkReset);
      pending.delete();
      errors = 0;
      void'(init_heap());
    endfunction

    function logic [31:0] rd(u64_t a);
      if ((a >> 2) >= WordCount) return '0;
      return tags[a >> 2];
    endfunction

    function void wr(u64_t a, u64_t v);
      if ((a >> 2) < WordCount) tags[a >> 2] = v[31:0];
    endfunction

    function u64_t bsize(u64_t bp);
      return u64_t'(rd(bp - 4) & 32'hFFFF_FFF8);
    endfunction

    function bit bused(u64_t bp);
      return 1'(rd(bp - 4) & 32'h1);
    endfunction

    function u64_t coalesce(u64_t bp);
      u64_t sz, prv, nxt, nsz, total;
      bit pu, nu;
      sz = bsize(bp);
      prv = bp - u64_t'(rd(bp - 8) & 32'hFFFF_FFF8);
      nxt = bp + sz;
      pu = bused(prv);
      nu = bused(nxt);
      if (!pu && !nu) begin
        nsz = bsize(nxt);
        total = sz + nsz + bsize(prv);
        wr(nxt + nsz - 8, total & ~u64_t'(7));
        wr(prv - 4, total & ~u64_t'(7));
        return prv;
      end
      if (!pu) begin
        total = sz + bsize(prv);
        wr(bp + sz - 8, total & ~u64_t'(7));
        wr(prv - 4, total & ~u64_t'(7));
        return prv;
      end
      total = nu ? sz : sz + bsize(nxt);
      total &= ~u64_t'(7);
      wr(bp - 4, total);
      wr(bp + total - 8, total);
      return bp;
    endfunction

    function bit extend(u64_t bytes, output u64_t bp_out);
      u64_t bp;
      bp = brk;
      bp_out = 0;
      if (bp + bytes > HeapBytesDef) return 0;
      brk = bp + bytes;
      wr(bp - 4, bytes);
      wr(bp + bytes - 8, bytes);
      wr(bp + bytes - 4, 1);
      bp_out = coalesce(bp);
      return 1;
    endfunction

    function u64_t chunk();
      u64_t c;
      c = (u64_t'(chunk_reg) + 7) & ~u64_t'(7);
      return (c == 0) ? 8 : c;
    endfunction

    function bit init_heap();
      u64_t bp;
      wr(0, 0);
      wr(4, 9);
      wr(8, 9);
      wr(12, 1);
      brk = 16;
      return extend(chunk(), bp);
    endfunction

    function void carve(u64_t bp, u64_t need);
      u64_t bsz, rest, nb;
      bsz = bsize(bp);
      if (bsz >= need + MinBlock) begin
        rest = bsz - need;
        nb = bp + need;
        wr(bp - 4, need | 1);
        wr(bp + need - 8, need | 1);
        wr(nb - 4, rest);
        wr(nb + rest - 8, rest);
      end else begin
        wr(bp - 4, bsz | 1);
        wr(bp + bsz - 8, bsz | 1);
      end
    endfunction

    function bit first_free(u64_t need, output u64_t bp_out);
      u64_t bp, sz;
      bp = 16;
      bp_out = 0;
      while (bp >= 4 && bp - 4 < HeapBytesDef) begin
        sz = bsize(bp);
        if (sz == 0) break;
        if (!bused(bp) && sz >= need) begin
          bp_out = bp;
          return 1;
        end
        bp += sz;
      end
      return 0;
    endfunction

    function logic [15:0] note_item(logic [1:0] cmd, logic [15:0] req, logic [15:0] ptr);
      alloc_result_t res;
      u64_t need, bp, ext, sz;
      res = '{address: '0, status: STAT_OK};
      case (cmd)
        CMD_ALLOC: begin
          if (req == 0) begin
            res.status = STAT_ZERO;
          end else begin
            need = (req < 8) ? MinBlock : ((u64_t'(req) + 15) / 8) * 8;
            if (first_free(need, bp)) begin
              carve(bp, need);
              res.address = bp[15:0];
            end else begin
              ext = (need > chunk()) ? need : chunk();
              if (extend(ext, bp)) begin
                carve(bp, need);
                res.address = bp[15:0];
              end else begin
                res.status = STAT_NOMEM;
              end
            end
          end
        end
        CMD_FREE: begin
          sz = bsize(ptr);
          wr(u64_t'(ptr) - 4, sz);
          wr(u64_t'(ptr) + sz - 8, sz);
          void'(coalesce(ptr));
        end
        CMD_INIT: begin
          if (!init_heap()) res.status = STAT_NOMEM;
        end
        default: ;
      endcase
      pending.push_back(res);
      return res.status == STAT_OK ? res.address : 16'd0;
    endfunction

    function void check_result(logic [15:0] address, logic [1:0] status);
      alloc_result_t exp_res;
      if (pending.size() == 0) begin
        $error("result with nothing expected: address %0d status %0d", address, status);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (address !== exp_res.address) begin
        $error("address: expected %0d, got %0d", exp_res.address, address);
        errors++;
      end
      if (status !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, status);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = CMD_ALLOC;
  logic [15:0] request_size_i = '0;
  logic [15:0] block_address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] address_o;
  logic [1:0]  status_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [16:0] extend_chunk_bytes_i = '0;

  heap_scoreboard sb;
  logic [15:0]    live_blocks[$];
  bit             calm = 0;
  bit             squeeze = 0;

  boundary_tag_heap_allocator dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    int burst;
    bit ready_run;
    burst = 0;
    ready_run = 1;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(address_o, status_o);
      if (squeeze) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        squeeze = 0;
        burst = 0;
      end
      if (burst == 0) begin
        ready_run = calm || ($urandom_range(0, 2) != 0);
        burst = $urandom_range(1, 18);
      end
      burst--;
      out_ready_i <= ready_run;
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [15:0] req, logic [15:0] ptr);
    logic [15:0] got;
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    request_size_i <= req;
    block_address_i <= ptr;
    do @(posedge clk_i); while (!in_ready_o);
    got = sb.note_item(cmd, req, ptr);
    if (cmd == CMD_ALLOC && got != 0) live_blocks.push_back(got);
    if (cmd == CMD_INIT) live_blocks.delete();
    if (!calm && !squeeze && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic free_some(int idx);
    logic [15:0] ptr;
    ptr = live_blocks[idx];
    live_blocks.delete(idx);
    send_item(CMD_FREE, 16'($urandom), ptr);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_chunk(logic [16:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    extend_chunk_bytes_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.chunk_reg = value;
  endtask

  task automatic random_items(int count);
    int pick;
    logic [15:0] req;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40 && live_blocks.size() != 0) begin
        free_some($urandom_range(0, live_blocks.size() - 1));
      end else if (pick < 43) begin
        send_item(CMD_INIT, 16'($urandom), 16'($urandom));
      end else if (pick < 45) begin
        send_item(CmdNone, 16'($urandom), 16'($urandom));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 4) req = 16'd0;
        else if (pick < 74) req = 16'($urandom_range(1, 256));
        else if (pick < 94) req = 16'($urandom_range(257, 4096));
        else req = 16'($urandom);
        send_item(CMD_ALLOC, req, 16'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear_heap();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(CMD_ALLOC, 16'd0, 16'hFFFF);
    send_item(CMD_ALLOC, 16'd1, 16'h0000);
    send_item(CMD_ALLOC, 16'd7, 16'hAAAA);
    send_item(CMD_ALLOC, 16'd8, 16'h5555);
    send_item(CMD_ALLOC, 16'd9, 16'h0000);
    send_item(CMD_ALLOC, 16'd4000, 16'h0000);
    send_item(CMD_ALLOC, 16'd65535, 16'h0000);
    send_item(CMD_ALLOC, 16'd5000, 16'h0000);
    send_item(CmdNone, 16'hFFFF, 16'hFFFF);
    free_some(1);
    free_some(2);
    free_some(1);
    free_some(0);
    free_some(live_blocks.size() - 1);
    send_item(CMD_ALLOC, 16'd30000, 16'h0000);
    send_item(CMD_ALLOC, 16'd30000, 16'h0000);
    send_item(CMD_INIT, 16'h0, 16'h0);
    send_item(CMD_ALLOC, 16'd100, 16'h0);

    write_chunk(17'd0);
    send_item(CMD_INIT, 16'h0, 16'h0);
    random_items(60);
    write_chunk(17'd65536);
    send_item(CMD_INIT, 16'h0, 16'h0);
    random_items(8);
    write_chunk(17'h1FFFF);
    send_item(CMD_INIT, 16'h0, 16'h0);
    random_items(8);
    write_chunk(17'd8);
    send_item(CMD_INIT, 16'h0, 16'h0);
    random_items(60);
    write_chunk(17'(ChunkReset));
    send_item(CMD_INIT, 16'h0, 16'h0);
    squeeze = 1;
    random_items(100);
    write_chunk(17'($urandom_range(1, 9000)));
    random_items(80);
    calm = 1;
    random_items(60);

    wait_drained();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
